// File: rtl/co2rd_pkg.sv
// Shared types, constants and codes for the CO2 reply-line parser.
package co2rd_pkg;

  // Field and register widths.
  localparam int unsigned CmdW  = 2;
  localparam int unsigned ByteW = 8;
  localparam int unsigned AccW  = 20;
  localparam int unsigned CntW  = 4;
  localparam int unsigned ValW  = 14;
  localparam int unsigned LimW  = 4;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 4;

  // Default number of digits kept from one line.
  localparam int unsigned MAX_DIGITS_DEF = 8;

  // Reset value of both limit registers.
  localparam logic [LimW-1:0] LIMIT_RST = 4'd10;

  // Saturation values.
  localparam logic [AccW-1:0] ACC_CAP  = 20'd999999;
  localparam logic [ValW-1:0] READ_CAP = 14'd9999;
  localparam logic [CntW-1:0] CNT_MAX  = 4'd15;

  // Division by 100 as a multiply by ceil(2^27 / 100) and a shift. The rounding
  // error stays below one hundredth over the whole accumulator range.
  localparam int unsigned DivMulW = 21;
  localparam int unsigned DIV100_SHIFT = 27;
  localparam logic [DivMulW-1:0] DIV100_MUL = 21'd1342178;

  // ASCII characters the parser reacts to.
  localparam logic [ByteW-1:0] CH_CR   = 8'h0d;
  localparam logic [ByteW-1:0] CH_EQ   = 8'h3d;
  localparam logic [ByteW-1:0] CH_STAR = 8'h2a;
  localparam logic [ByteW-1:0] CH_ZERO = 8'h30;
  localparam logic [ByteW-1:0] CH_NINE = 8'h39;

  // Item commands.
  typedef enum logic [CmdW-1:0] {
    CMD_BYTE  = 2'd0,
    CMD_CHECK = 2'd1,
    CMD_POLL  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_CHECK_LIMIT = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_RETRY_LIMIT = 1'd1;

  // Control from the sequencing logic to the line buffer.
  typedef struct packed {
    logic take_byte;
    logic clear;
  } line_ctl_t;

  // Status of the current line as seen by the sequencing logic.
  typedef struct packed {
    logic            line_done;
    logic            star_seen;
    logic            has_digits;
    logic [ValW-1:0] reading_new;
  } line_sts_t;

endpackage

// File: rtl/co2_ascii_reading_parser_top.sv
// Top level of the CO2 reply-line parser: handshakes, counters and result register.
//
//  Channel  Direction  Handshake               Payload
//  -------  ---------  ----------------------  -----------------------------------
//  in       input      in_valid_i / in_stall_o  cmd_i, rx_byte_i
//  out      output     out_valid_o/out_stall_i  co2_value_o, sensor_error_o,
//                                               send_request_o, value_updated_o
//  cfg      input      cfg_we_i                 cfg_idx_i, cfg_data_i
//
// One item per cycle while the output is not stalled. The input register feeds one
// pass of parse, divide-by-100 and counter logic into the result register. An output
// stall holds the result register and backs up into the input register, so up to two
// items are in flight. Reset clears the line, the counters, the reading and the error
// bit and sets both limits to ten.
module co2_ascii_reading_parser_top
  import co2rd_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [CmdW-1:0]     cmd_i,
  input  logic [ByteW-1:0]    rx_byte_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [ValW-1:0]     co2_value_o,
  output logic                sensor_error_o,
  output logic                send_request_o,
  output logic                value_updated_o
);

  // Input register.
  logic             in_vld_q;
  cmd_e             cmd_q;
  logic [ByteW-1:0] byte_q;

  // Result register.
  logic            out_vld_q;
  logic [ValW-1:0] value_q;
  logic            error_q;
  logic            send_q;
  logic            upd_q;

  // Block state.
  logic [LimW-1:0] check_lim_q;
  logic [LimW-1:0] retry_lim_q;
  logic [CntW-1:0] check_cnt_q, check_cnt_d;
  logic [CntW-1:0] resend_cnt_q, resend_cnt_d;
  logic [ValW-1:0] reading_q, reading_d;
  logic            err_q, err_d;
  logic            send_d;
  logic            upd_d;
  logic [CntW-1:0] resend_inc;

  logic      advance;
  logic      fire;
  logic      in_accept;
  line_ctl_t line_ctl;
  line_sts_t line_sts;

  // Pipeline flow control.
  assign advance    = !out_vld_q || !out_stall_i;
  assign fire       = in_vld_q && advance;
  assign in_stall_o = in_vld_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_accept) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q  <= cmd_e'(cmd_i);
      byte_q <= rx_byte_i;
    end
  end

  // Line buffer.
  co2rd_line #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_line (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (line_ctl),
    .byte_i (byte_q),
    .sts_o  (line_sts)
  );

  assign resend_inc = (resend_cnt_q < CNT_MAX) ? resend_cnt_q + 4'd1 : resend_cnt_q;

  // Command handling for the item in the input register.
  always_comb begin
    check_cnt_d        = check_cnt_q;
    resend_cnt_d       = resend_cnt_q;
    reading_d          = reading_q;
    err_d              = err_q;
    send_d             = 1'b0;
    upd_d              = 1'b0;
    line_ctl.take_byte = 1'b0;
    line_ctl.clear     = 1'b0;
    if (fire) begin
      case (cmd_q)
        CMD_BYTE: begin
          line_ctl.take_byte = 1'b1;
        end
        CMD_CHECK: begin
          if (check_cnt_q < CNT_MAX) begin
            check_cnt_d = check_cnt_q + 4'd1;
          end
          if (line_sts.line_done) begin
            if (line_sts.has_digits) begin
              reading_d      = line_sts.reading_new;
              err_d          = 1'b0;
              line_ctl.clear = 1'b1;
              check_cnt_d    = check_lim_q;
              resend_cnt_d   = '0;
              upd_d          = 1'b1;
            end else if (line_sts.star_seen) begin
              reading_d = '0;
              err_d     = 1'b1;
            end
          end
        end
        CMD_POLL: begin
          if (check_cnt_q >= check_lim_q) begin
            send_d         = 1'b1;
            line_ctl.clear = 1'b1;
            check_cnt_d    = '0;
            resend_cnt_d   = resend_inc;
            if (resend_inc >= retry_lim_q) begin
              reading_d    = '0;
              err_d        = 1'b1;
              resend_cnt_d = retry_lim_q;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // State and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      check_lim_q  <= LIMIT_RST;
      retry_lim_q  <= LIMIT_RST;
      check_cnt_q  <= '0;
      resend_cnt_q <= '0;
      reading_q    <= '0;
      err_q        <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_idx_i == CFG_CHECK_LIMIT)) begin
        check_lim_q <= cfg_data_i;
      end
      if (cfg_we_i && (cfg_idx_i == CFG_RETRY_LIMIT)) begin
        retry_lim_q <= cfg_data_i;
      end
      check_cnt_q  <= check_cnt_d;
      resend_cnt_q <= resend_cnt_d;
      reading_q    <= reading_d;
      err_q        <= err_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      value_q <= reading_d;
      error_q <= err_d;
      send_q  <= send_d;
      upd_q   <= upd_d;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign co2_value_o     = value_q;
  assign sensor_error_o  = error_q;
  assign send_request_o  = send_q;
  assign value_updated_o = upd_q;

`ifndef SYNTHESIS
  a_upd_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && upd_q) |-> !error_q)
    else $error("fresh reading reported with error bit set");
  a_value_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    reading_q <= READ_CAP)
    else $error("reading beyond cap");
  a_send_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && send_d) |=> (check_cnt_q == '0))
    else $error("check count not cleared after resend");
  a_none_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (cmd_q == CMD_NONE)) |=> ($stable(reading_q) && $stable(err_q)))
    else $error("unused command changed the reading");
`endif

endmodule

// File: rtl/co2rd_line.sv
// Line buffer: collects the digits of one sensor reply line.
module co2rd_line
  import co2rd_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  line_ctl_t        ctl_i,
  input  logic [ByteW-1:0] byte_i,
  output line_sts_t        sts_o
);

  localparam int unsigned CntDW = $clog2(MAX_DIGITS + 1);

  logic             seen_eq_q, seen_eq_d;
  logic             done_q, done_d;
  logic             star_q, star_d;
  logic [AccW-1:0]  acc_q, acc_d;
  logic [CntDW-1:0] cnt_q, cnt_d;

  logic                      is_digit;
  logic [AccW+3:0]           acc_x10;
  logic [AccW+3:0]           acc_sum;
  logic [AccW+DivMulW-1:0]   div_prod;
  logic [ValW-1:0]           div_quot;

  // Next digit accumulator value, saturating at the largest figure kept.
  assign is_digit = (byte_i >= CH_ZERO) && (byte_i <= CH_NINE);
  assign acc_x10  = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0};
  assign acc_sum  = acc_x10 + {{AccW{1'b0}}, byte_i[3:0]};

  // Byte parsing and line clearing.
  always_comb begin
    seen_eq_d = seen_eq_q;
    done_d    = done_q;
    star_d    = star_q;
    acc_d     = acc_q;
    cnt_d     = cnt_q;
    if (ctl_i.clear) begin
      seen_eq_d = 1'b0;
      done_d    = 1'b0;
      star_d    = 1'b0;
      acc_d     = '0;
      cnt_d     = '0;
    end else if (ctl_i.take_byte && !done_q) begin
      if (byte_i == CH_CR) begin
        done_d = 1'b1;
      end else if (!seen_eq_q) begin
        if (byte_i == CH_EQ) begin
          seen_eq_d = 1'b1;
        end
      end else if (!star_q) begin
        if (is_digit) begin
          if (cnt_q < CntDW'(MAX_DIGITS)) begin
            acc_d = (acc_sum > {4'd0, ACC_CAP}) ? ACC_CAP : acc_sum[AccW-1:0];
            cnt_d = cnt_q + CntDW'(1);
          end
        end else if (byte_i == CH_STAR) begin
          star_d = 1'b1;
        end
      end
    end
  end

  // Line state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_eq_q <= 1'b0;
      done_q    <= 1'b0;
      star_q    <= 1'b0;
      acc_q     <= '0;
      cnt_q     <= '0;
    end else begin
      seen_eq_q <= seen_eq_d;
      done_q    <= done_d;
      star_q    <= star_d;
      acc_q     <= acc_d;
      cnt_q     <= cnt_d;
    end
  end

  // Reading in hundreds of ppm from the gathered figure.
  assign div_prod = acc_q * DIV100_MUL;
  assign div_quot = div_prod[DIV100_SHIFT +: ValW];

  assign sts_o.line_done   = done_q;
  assign sts_o.star_seen   = star_q;
  assign sts_o.has_digits  = (cnt_q != '0);
  assign sts_o.reading_new = (div_quot > READ_CAP) ? READ_CAP : div_quot;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntDW'(MAX_DIGITS))
    else $error("digit count beyond limit");
  a_acc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_q <= ACC_CAP)
    else $error("accumulator beyond cap");
  a_star_after_eq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    star_q |-> seen_eq_q)
    else $error("star recorded before equals sign");
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.clear |=> (cnt_q == '0) && !done_q && !star_q)
    else $error("line not cleared");
`endif

endmodule

// File: tb/co2_ascii_reading_parser_top_tb.sv
// Self-checking testbench for the CO2 reply-line parser top level.
module co2_ascii_reading_parser_top_tb;
  import co2rd_pkg::*;

  // One parser result, in port order.
  typedef struct packed {
    logic [ValW-1:0] co2;
    logic            err;
    logic            send;
    logic            updated;
  } result_t;

  // One input transaction, optionally with a hand-written result.
  typedef struct packed {
    cmd_e             cmd;
    logic [ByteW-1:0] rx;
    logic             known;
    result_t          res;
  } item_t;

  localparam int unsigned CycleLimit = 200000;

  localparam result_t NoRes = '0;

  // Directed lines: unused command, CR before '=', an early resend, a line with
  // too many digits and a saturated figure, bytes after '*' and after CR, a '*'
  // field with no digits, and the retry limit reached. Check limit 1, retry limit 2.
  localparam item_t DirTbl [26] = '{
    '{CMD_NONE,  8'hff,   1'b1, '{14'd0,    1'b0, 1'b0, 1'b0}},
    '{CMD_BYTE,  CH_CR,   1'b1, '{14'd0,    1'b0, 1'b0, 1'b0}},
    '{CMD_CHECK, 8'h00,   1'b1, '{14'd0,    1'b0, 1'b0, 1'b0}},
    '{CMD_POLL,  8'h00,   1'b1, '{14'd0,    1'b0, 1'b1, 1'b0}},
    '{CMD_BYTE,  8'h00,   1'b0, NoRes},
    '{CMD_BYTE,  CH_EQ,   1'b0, NoRes},
    '{CMD_BYTE,  CH_NINE, 1'b0, NoRes},
    '{CMD_BYTE,  CH_NINE, 1'b0, NoRes},
    '{CMD_BYTE,  CH_NINE, 1'b0, NoRes},
    '{CMD_BYTE,  CH_NINE, 1'b0, NoRes},
    '{CMD_BYTE,  CH_NINE, 1'b0, NoRes},
    '{CMD_BYTE,  CH_NINE, 1'b0, NoRes},
    '{CMD_BYTE,  CH_NINE, 1'b0, NoRes},
    '{CMD_BYTE,  CH_NINE, 1'b0, NoRes},
    '{CMD_BYTE,  CH_NINE, 1'b0, NoRes},
    '{CMD_BYTE,  CH_STAR, 1'b0, NoRes},
    '{CMD_BYTE,  8'h35,   1'b0, NoRes},
    '{CMD_BYTE,  CH_CR,   1'b0, NoRes},
    '{CMD_BYTE,  8'h37,   1'b0, NoRes},
    '{CMD_CHECK, 8'hff,   1'b1, '{READ_CAP, 1'b0, 1'b0, 1'b1}},
    '{CMD_POLL,  8'h5a,   1'b1, '{READ_CAP, 1'b0, 1'b1, 1'b0}},
    '{CMD_BYTE,  CH_EQ,   1'b0, NoRes},
    '{CMD_BYTE,  CH_STAR, 1'b0, NoRes},
    '{CMD_BYTE,  CH_CR,   1'b0, NoRes},
    '{CMD_CHECK, 8'h00,   1'b1, '{14'd0,    1'b1, 1'b0, 1'b0}},
    '{CMD_POLL,  8'hff,   1'b1, '{14'd0,    1'b1, 1'b1, 1'b0}}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [CmdW-1:0]     cmd_i;
  logic [ByteW-1:0]    rx_byte_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [ValW-1:0]     co2_value_o;
  logic                sensor_error_o;
  logic                send_request_o;
  logic                value_updated_o;

  // Model state of the parser and its limit registers.
  logic             p_seen_eq   = 1'b0;
  logic             p_line_end  = 1'b0;
  logic             p_star      = 1'b0;
  logic [AccW-1:0]  p_acc       = '0;
  logic [CntW-1:0]  p_ndig      = '0;
  logic [CntW-1:0]  p_chk_cnt   = '0;
  logic [CntW-1:0]  p_rsnd_cnt  = '0;
  logic [ValW-1:0]  p_reading   = '0;
  logic             p_err       = 1'b0;
  logic [LimW-1:0]  lim_chk     = LIMIT_RST;
  logic [LimW-1:0]  lim_rty     = LIMIT_RST;

  item_t       line_items_q[$];
  result_t     expected_readings[$];
  item_t       cur_item;
  result_t     predicted;
  result_t     want;
  logic        running = 1'b0;
  int          src_idle_pct = 0;
  int          dst_idle_pct = 0;
  int unsigned cycle_count = 0;
  int unsigned fails = 0;
  int unsigned n_items = 0;
  int unsigned n_results = 0;
  int unsigned n_updates = 0;
  int unsigned n_sends = 0;
  int unsigned n_errors = 0;

  co2_ascii_reading_parser_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .co2_value_o    (co2_value_o),
    .sensor_error_o (sensor_error_o),
    .send_request_o (send_request_o),
    .value_updated_o(value_updated_o)
  );

  // Clock generation.
  always #5 clk_i = ~clk_i;

  // Run time guard.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Drop the partial line the parser is gathering.
  task automatic forget_line();
    p_seen_eq  = 1'b0;
    p_line_end = 1'b0;
    p_star     = 1'b0;
    p_acc      = '0;
    p_ndig     = '0;
  endtask

  // Advance the parser model by one transaction and return its result.
  task automatic predict_reading(input cmd_e cmd, input logic [ByteW-1:0] rx,
                                 output result_t res);
    int unsigned acc_next;
    int unsigned quo;
    res = '0;
    case (cmd)
      CMD_BYTE: begin
        if (!p_line_end) begin
          if (rx == CH_CR) begin
            p_line_end = 1'b1;
          end else if (!p_seen_eq) begin
            if (rx == CH_EQ) p_seen_eq = 1'b1;
          end else if (!p_star) begin
            if (rx >= CH_ZERO && rx <= CH_NINE) begin
              if (p_ndig < MAX_DIGITS_DEF) begin
                acc_next = p_acc * 10 + (rx - CH_ZERO);
                p_acc = (acc_next > ACC_CAP) ? ACC_CAP : acc_next[AccW-1:0];
                p_ndig++;
              end
            end else if (rx == CH_STAR) begin
              p_star = 1'b1;
            end
          end
        end
      end
      CMD_CHECK: begin
        if (p_chk_cnt != CNT_MAX) p_chk_cnt++;
        if (p_line_end) begin
          if (p_ndig != 0) begin
            quo = p_acc / 100;
            p_reading = (quo > READ_CAP) ? READ_CAP : quo[ValW-1:0];
            p_err = 1'b0;
            forget_line();
            p_chk_cnt = lim_chk;
            p_rsnd_cnt = '0;
            res.updated = 1'b1;
          end else if (p_star) begin
            p_reading = '0;
            p_err = 1'b1;
          end
        end
      end
      CMD_POLL: begin
        if (p_chk_cnt >= lim_chk) begin
          res.send = 1'b1;
          forget_line();
          p_chk_cnt = '0;
          if (p_rsnd_cnt != CNT_MAX) p_rsnd_cnt++;
          if (p_rsnd_cnt >= lim_rty) begin
            p_reading = '0;
            p_err = 1'b1;
            p_rsnd_cnt = lim_rty;
          end
        end
      end
      default: begin
      end
    endcase
    res.co2 = p_reading;
    res.err = p_err;
  endtask

  // Queue a transaction whose result comes from the model.
  task automatic queue_item(input cmd_e c, input logic [ByteW-1:0] b);
    item_t it;
    it = '0;
    it.cmd = c;
    it.rx = b;
    line_items_q.push_back(it);
  endtask

  // Write both limit registers; the parser must be idle.
  task automatic set_limits(input logic [LimW-1:0] chk, input logic [LimW-1:0] rty);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_CHECK_LIMIT;
    cfg_data_i <= chk;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_RETRY_LIMIT;
    cfg_data_i <= rty;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    lim_chk = chk;
    lim_rty = rty;
  endtask

  // Wait until every queued transaction has produced its result.
  task automatic wait_drained();
    while (line_items_q.size() != 0 || in_valid_i || expected_readings.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Random phase: mostly well-formed reply lines, plus silence and noise.
  task automatic run_phase(input int src_pct, input int dst_pct,
                           input logic [LimW-1:0] chk, input logic [LimW-1:0] rty,
                           input int n);
    int shape;
    int ndig;
    set_limits(chk, rty);
    src_idle_pct = src_pct;
    dst_idle_pct = dst_pct;
    while (line_items_q.size() < n) begin
      shape = $urandom_range(99);
      if (shape < 65) begin
        // Reply line, sometimes broken: missing '=', a '*' field or no CR.
        repeat ($urandom_range(4)) queue_item(CMD_BYTE, 8'($urandom_range(8'h30, 8'h5a)));
        if (shape >= 3) queue_item(CMD_BYTE, CH_EQ);
        if ($urandom_range(9) == 0) ndig = $urandom_range(8, 10);
        else ndig = $urandom_range(7);
        repeat (ndig) queue_item(CMD_BYTE, 8'(CH_ZERO + $urandom_range(9)));
        if (shape >= 3 && shape < 12) begin
          queue_item(CMD_BYTE, CH_STAR);
          repeat ($urandom_range(2)) queue_item(CMD_BYTE, 8'(CH_ZERO + $urandom_range(9)));
        end else if ($urandom_range(1) == 1) begin
          queue_item(CMD_BYTE, 8'h20);
          queue_item(CMD_BYTE, 8'h70);
          queue_item(CMD_BYTE, 8'h70);
          queue_item(CMD_BYTE, 8'h6d);
        end
        if (shape >= 8) queue_item(CMD_BYTE, CH_CR);
        if ($urandom_range(3) == 0) queue_item(CMD_BYTE, 8'($urandom_range(255)));
        repeat ($urandom_range(1, 2)) queue_item(CMD_CHECK, 8'($urandom_range(255)));
        repeat ($urandom_range(2)) queue_item(CMD_POLL, 8'($urandom_range(255)));
      end else if (shape < 82) begin
        // Sensor silent: checks and polls only.
        repeat ($urandom_range(2, 12))
          queue_item($urandom_range(1) ? CMD_CHECK : CMD_POLL, 8'($urandom_range(255)));
      end else begin
        repeat ($urandom_range(1, 6))
          queue_item(cmd_e'($urandom_range(3)), 8'($urandom_range(255)));
      end
    end
    wait_drained();
  endtask

  // Input side: present transactions and feed accepted ones to the model.
  always @(posedge clk_i) begin
    if (running) begin
      if (in_valid_i && !in_stall_o) begin
        predict_reading(cur_item.cmd, cur_item.rx, predicted);
        if (cur_item.known) expected_readings.push_back(cur_item.res);
        else expected_readings.push_back(predicted);
        n_items++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (line_items_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          cur_item = line_items_q.pop_front();
          in_valid_i <= 1'b1;
          cmd_i      <= cur_item.cmd;
          rx_byte_i  <= cur_item.rx;
        end else begin
          in_valid_i <= 1'b0;
          cmd_i      <= CmdW'($urandom_range(3));
          rx_byte_i  <= ByteW'($urandom_range(255));
        end
      end
    end
  end

  // Output side: check each result against the oldest expectation.
  always @(posedge clk_i) begin
    if (running) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_readings.size() == 0) begin
          $error("result transaction with no input waiting for it");
          fails++;
        end else begin
          want = expected_readings.pop_front();
          n_results++;
          if (value_updated_o === 1'b1) n_updates++;
          if (send_request_o === 1'b1) n_sends++;
          if (sensor_error_o === 1'b1) n_errors++;
          if (co2_value_o !== want.co2) begin
            $error("co2_value: expected %0d, got %0d", want.co2, co2_value_o);
            fails++;
          end
          if (sensor_error_o !== want.err) begin
            $error("sensor_error: expected %0b, got %0b", want.err, sensor_error_o);
            fails++;
          end
          if (send_request_o !== want.send) begin
            $error("send_request: expected %0b, got %0b", want.send, send_request_o);
            fails++;
          end
          if (value_updated_o !== want.updated) begin
            $error("value_updated: expected %0b, got %0b", want.updated, value_updated_o);
            fails++;
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < dst_idle_pct);
    end
  end

  // Test sequence.
  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    cmd_i       = '0;
    rx_byte_i   = '0;
    out_stall_i = 1'b0;
    cur_item    = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_limits(4'd1, 4'd2);

    // Walk the directed table.
    foreach (DirTbl[k]) line_items_q.push_back(DirTbl[k]);
    running = 1'b1;
    wait_drained();

    run_phase(24, 63, 4'd4, 4'd3, 280);
    run_phase(63, 24, 4'd15, 4'd15, 280);
    run_phase(0, 0, 4'd1, 4'd1, 270);
    run_phase(0, 0, 4'd0, 4'd9, 270);

    if (expected_readings.size() != 0) begin
      $error("%0d expected results never arrived", expected_readings.size());
      fails++;
    end
    $display("Checked %0d results for %0d input transactions under five limit settings.",
             n_results, n_items);
    $display("Seen: %0d fresh readings, %0d resend requests, %0d results with sensor error.",
             n_updates, n_sends, n_errors);
    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: co2_ascii_reading_parser_top.f
rtl/co2rd_pkg.sv
rtl/co2rd_line.sv
rtl/co2_ascii_reading_parser_top.sv
tb/co2_ascii_reading_parser_top_tb.sv
